@@ rtl/rvlp_pkg.sv @@
// shared types and constants of the raw video line packetizer
package rvlp_pkg;

	localparam int LUMA_W    = 8;
	localparam int FRAME_W   = 32;
	localparam int WORD_W    = 16;
	localparam int WIDTH_W   = 10;
	localparam int HEIGHT_W  = 16;
	localparam int TICKS_W   = 25;
	localparam int LINE_W    = 15;
	localparam int SEQ_W     = 32;
	localparam int TS_W      = 32;
	localparam int TS_FRAC   = 8;
	localparam int PROD_W    = TS_W + TS_FRAC;
	localparam int CNT_W     = 4;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TICKS        = 2'd2;

	localparam logic [WIDTH_W-1:0]  LINE_WIDTH_RST   = 10'd400;
	localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd400;
	localparam logic [TICKS_W-1:0]  TICKS_RST        = 25'd256000;

	localparam logic [7:0] VERSION_BYTE   = 8'h80;
	localparam logic [7:0] PAYLOAD_TYPE   = 8'h7F;
	localparam logic [7:0] MARKER_BIT     = 8'h80;
	localparam logic [7:0] CHROMA_NEUTRAL = 8'h80;
	localparam logic [7:0] PAD_BYTE       = 8'h00;

	// word positions within one line start burst
	localparam logic [CNT_W-1:0] W_VER     = 4'd0;
	localparam logic [CNT_W-1:0] W_SEQ_LO  = 4'd1;
	localparam logic [CNT_W-1:0] W_TS_HI   = 4'd2;
	localparam logic [CNT_W-1:0] W_TS_LO   = 4'd3;
	localparam logic [CNT_W-1:0] W_SSRC_HI = 4'd4;
	localparam logic [CNT_W-1:0] W_SSRC_LO = 4'd5;
	localparam logic [CNT_W-1:0] W_SEQ_HI  = 4'd6;
	localparam logic [CNT_W-1:0] W_LEN     = 4'd7;
	localparam logic [CNT_W-1:0] W_LINE    = 4'd8;
	localparam logic [CNT_W-1:0] W_OFFSET  = 4'd9;
	localparam logic [CNT_W-1:0] W_PIXEL   = 4'd10;

	typedef struct packed {
		logic [LUMA_W-1:0]  luma;
		logic [FRAME_W-1:0] frame_number;
		logic               hdr;
		logic               last_row;
		logic               end_line;
		logic [SEQ_W-1:0]   seq;
		logic [LINE_W-1:0]  line;
	} item_t;

endpackage

@@ rtl/rvlp_if.sv @@
// stream interfaces for pixels in and packet words out
interface rvlp_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [rvlp_pkg::LUMA_W-1:0]  luma;
	logic [rvlp_pkg::FRAME_W-1:0] frame_number;

	modport source (output valid, luma, frame_number, input ready);
	modport sink (input valid, luma, frame_number, output ready);
endinterface

interface rvlp_word_if;
	logic                        valid;
	logic                        ready;
	logic [rvlp_pkg::WORD_W-1:0] packet_word;
	logic                        end_of_packet;
	logic                        last_of_run;

	modport source (output valid, packet_word, end_of_packet, last_of_run, input ready);
	modport sink (input valid, packet_word, end_of_packet, last_of_run, output ready);
endinterface

@@ rtl/raw_video_line_packetizer.sv @@
// raw video line packetizer: pixels in, rtp raw video packet words out
// a pixel is registered in the input stage, then in the word emitter stage, before its first word is offered
// throughput: one pixel per cycle mid-line while the output is ready; a line's first pixel
// is held for ten header words and its pixel word, set by the single word output port
// reset: line position, sequence count and stages clear; registers take defaults
module raw_video_line_packetizer (
	input  logic                          clk,
	input  logic                          arst_n,
	rvlp_pixel_if.sink                    pix,
	rvlp_word_if.source                   pkt,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rvlp_pkg::APB_AW-1:0]   paddr,
	input  logic [rvlp_pkg::APB_DW-1:0]   pwdata,
	output logic [rvlp_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	logic [rvlp_pkg::WIDTH_W-1:0]  line_width_q;
	logic [rvlp_pkg::HEIGHT_W-1:0] frame_height_q;
	logic [rvlp_pkg::TICKS_W-1:0]  ticks_q;

	logic [rvlp_pkg::SEQ_W-1:0]    seq_q;
	logic [rvlp_pkg::LINE_W-1:0]   line_q;
	logic [rvlp_pkg::WIDTH_W-1:0]  col_q;

	logic                          valid_s1;
	rvlp_pkg::item_t               item_s1;
	logic                          valid_s2;
	rvlp_pkg::item_t               item_s2;
	logic [rvlp_pkg::TS_W-1:0]     ts_s2;
	logic [rvlp_pkg::CNT_W-1:0]    cnt_s2;

	logic                          wr_en;
	logic [1:0]                    reg_idx;
	logic [rvlp_pkg::WIDTH_W-1:0]  w_eff;
	logic [rvlp_pkg::HEIGHT_W-1:0] h_eff;
	logic                          last_row;
	logic                          end_line;
	logic                          in_fire;
	logic                          s2_done;
	logic                          s1_move;
	logic [rvlp_pkg::PROD_W-1:0]   prod;

	// apb port
	assign pready  = 1'b1;
	assign reg_idx = paddr[rvlp_pkg::APB_AW-1:2];
	assign wr_en   = psel & penable & pwrite;

	always_comb begin
		case (reg_idx)
			rvlp_pkg::REG_LINE_WIDTH:   prdata = {22'd0, line_width_q};
			rvlp_pkg::REG_FRAME_HEIGHT: prdata = {16'd0, frame_height_q};
			rvlp_pkg::REG_TICKS:        prdata = {7'd0, ticks_q};
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= rvlp_pkg::LINE_WIDTH_RST;
			frame_height_q <= rvlp_pkg::FRAME_HEIGHT_RST;
			ticks_q        <= rvlp_pkg::TICKS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				rvlp_pkg::REG_LINE_WIDTH:   line_width_q   <= pwdata[rvlp_pkg::WIDTH_W-1:0];
				rvlp_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[rvlp_pkg::HEIGHT_W-1:0];
				rvlp_pkg::REG_TICKS:        ticks_q        <= pwdata[rvlp_pkg::TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	// line position, a zero size acts as one
	assign w_eff     = (line_width_q == '0) ? 10'd1 : line_width_q;
	assign h_eff     = (frame_height_q == '0) ? 16'd1 : frame_height_q;
	assign last_row  = ({1'b0, line_q} + 16'd1) >= h_eff;
	assign end_line  = ({1'b0, col_q} + 11'd1) >= {1'b0, w_eff};

	assign s2_done = valid_s2 & pkt.ready & (cnt_s2 == rvlp_pkg::W_PIXEL);
	assign s1_move = !valid_s2 || s2_done;
	assign pix.ready = !valid_s1 || s1_move;
	assign in_fire = pix.valid & pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= '0;
			line_q <= '0;
			col_q  <= '0;
		end else if (in_fire) begin
			if (end_line) begin
				col_q <= '0;
				seq_q <= seq_q + 32'd1;
				line_q <= last_row ? '0 : line_q + 15'd1;
			end else begin
				col_q <= col_q + 10'd1;
			end
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.luma         <= pix.luma;
			item_s1.frame_number <= pix.frame_number;
			item_s1.hdr          <= (col_q == '0);
			item_s1.last_row     <= last_row;
			item_s1.end_line     <= end_line;
			item_s1.seq          <= seq_q;
			item_s1.line         <= line_q;
		end
	end

	// timestamp, only the low 40 bits of the product matter
	assign prod = rvlp_pkg::PROD_W'({15'd0, ticks_q} * {8'd0, item_s1.frame_number});

	// word emitter stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_s2   <= rvlp_pkg::W_VER;
		end else if (s1_move) begin
			valid_s2 <= valid_s1;
			cnt_s2   <= item_s1.hdr ? rvlp_pkg::W_VER : rvlp_pkg::W_PIXEL;
		end else if (pkt.ready) begin
			cnt_s2 <= cnt_s2 + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			item_s2 <= item_s1;
			ts_s2   <= prod[rvlp_pkg::PROD_W-1:rvlp_pkg::TS_FRAC];
		end
	end

	assign pkt.valid         = valid_s2;
	assign pkt.last_of_run   = (cnt_s2 == rvlp_pkg::W_PIXEL);
	assign pkt.end_of_packet = (cnt_s2 == rvlp_pkg::W_PIXEL) & item_s2.end_line;

	always_comb begin
		case (cnt_s2)
			rvlp_pkg::W_VER: pkt.packet_word = {rvlp_pkg::VERSION_BYTE,
				(item_s2.last_row ? rvlp_pkg::MARKER_BIT : rvlp_pkg::PAD_BYTE)
				| rvlp_pkg::PAYLOAD_TYPE};
			rvlp_pkg::W_SEQ_LO:  pkt.packet_word = item_s2.seq[15:0];
			rvlp_pkg::W_TS_HI:   pkt.packet_word = ts_s2[31:16];
			rvlp_pkg::W_TS_LO:   pkt.packet_word = ts_s2[15:0];
			rvlp_pkg::W_SSRC_HI: pkt.packet_word = {rvlp_pkg::PAD_BYTE, rvlp_pkg::PAD_BYTE};
			rvlp_pkg::W_SSRC_LO: pkt.packet_word = {rvlp_pkg::PAD_BYTE, rvlp_pkg::PAD_BYTE};
			rvlp_pkg::W_SEQ_HI:  pkt.packet_word = item_s2.seq[31:16];
			rvlp_pkg::W_LEN:     pkt.packet_word = {5'd0, w_eff, 1'b0};
			rvlp_pkg::W_LINE:    pkt.packet_word = {1'b0, item_s2.line};
			rvlp_pkg::W_OFFSET:  pkt.packet_word = {rvlp_pkg::PAD_BYTE, rvlp_pkg::PAD_BYTE};
			rvlp_pkg::W_PIXEL:   pkt.packet_word = {rvlp_pkg::CHROMA_NEUTRAL, item_s2.luma};
			default:             pkt.packet_word = '0;
		endcase
	end

endmodule
